[rtl/assert_macros.svh]
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication across reset");

`endif

[rtl/iv3_pkg.sv]
// shared widths, register indexes and position type of the integral volume block
package iv3_pkg;

   localparam int MAX_WIDTH   = 512;
   localparam int MAX_HEIGHT  = 512;
   localparam int MAX_FRAMES  = 16;

   localparam int SAMPLE_W    = 16;
   localparam int SUM_W       = 38;
   localparam int LINE_W      = 34;
   localparam int ROW_SUM_W   = 25;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int FRAME_W     = $clog2(MAX_FRAMES);
   localparam int VOL_ADDR_W  = ROW_W + COL_W;

   localparam int CSR_DATA_W  = 10;
   localparam int CSR_INDEX_W = 2;
   localparam int WIDTH_CFG_W = 10;
   localparam int HEIGHT_CFG_W = 10;
   localparam int COUNT_CFG_W = 5;

   // in-flight item count of the checker (three pipeline registers)
   localparam int INFLIGHT_W  = 3;
   localparam int MAX_INFLIGHT = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_FRAME_COUNT  = 2'd2
   } reg_index_type;

   // position of one pixel and the flags derived from it
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             row_zero;
      logic             frame_zero;
      logic             end_col;
      logic             last;
   } pos_type;

endpackage

[rtl/iv3_pos.sv]
// size registers and column, row and frame position counters
module iv3_pos (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [iv3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [iv3_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            advance,
   output iv3_pkg::pos_type                pos
);
   import iv3_pkg::*;

   // last used index of each dimension, kept saturated
   logic [COL_W-1:0]   width_last_ff;
   logic [ROW_W-1:0]   height_last_ff;
   logic [FRAME_W-1:0] frame_last_ff;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;

   logic [WIDTH_CFG_W-1:0]  width_cfg;
   logic [HEIGHT_CFG_W-1:0] height_cfg;
   logic [COUNT_CFG_W-1:0]  count_cfg;
   logic [COL_W-1:0]        width_last_in;
   logic [ROW_W-1:0]        height_last_in;
   logic [FRAME_W-1:0]      frame_last_in;
   logic                    end_col, end_row, end_frame;

   assign width_cfg  = csr_wdata[WIDTH_CFG_W-1:0];
   assign height_cfg = csr_wdata[HEIGHT_CFG_W-1:0];
   assign count_cfg  = csr_wdata[COUNT_CFG_W-1:0];

   always_comb begin
      if (width_cfg < WIDTH_CFG_W'(2)) begin
         width_last_in = COL_W'(1);
      end else if (width_cfg > WIDTH_CFG_W'(MAX_WIDTH)) begin
         width_last_in = COL_W'(MAX_WIDTH - 1);
      end else begin
         width_last_in = COL_W'(width_cfg - WIDTH_CFG_W'(1));
      end
      if (height_cfg < HEIGHT_CFG_W'(2)) begin
         height_last_in = ROW_W'(1);
      end else if (height_cfg > HEIGHT_CFG_W'(MAX_HEIGHT)) begin
         height_last_in = ROW_W'(MAX_HEIGHT - 1);
      end else begin
         height_last_in = ROW_W'(height_cfg - HEIGHT_CFG_W'(1));
      end
      if (count_cfg < COUNT_CFG_W'(1)) begin
         frame_last_in = '0;
      end else if (count_cfg > COUNT_CFG_W'(MAX_FRAMES)) begin
         frame_last_in = FRAME_W'(MAX_FRAMES - 1);
      end else begin
         frame_last_in = FRAME_W'(count_cfg - COUNT_CFG_W'(1));
      end
   end

   assign end_col   = col_ff >= width_last_ff;
   assign end_row   = row_ff >= height_last_ff;
   assign end_frame = frame_ff >= frame_last_ff;

   always_comb begin
      col_in   = col_ff + COL_W'(1);
      row_in   = row_ff;
      frame_in = frame_ff;
      if (end_col) begin
         col_in = '0;
         if (end_row) begin
            row_in   = '0;
            frame_in = end_frame ? '0 : frame_ff + FRAME_W'(1);
         end else begin
            row_in = row_ff + ROW_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= COL_W'(MAX_WIDTH - 1);
         height_last_ff <= ROW_W'(MAX_HEIGHT - 1);
         frame_last_ff  <= FRAME_W'(MAX_FRAMES - 1);
         col_ff         <= '0;
         row_ff         <= '0;
         frame_ff       <= '0;
      end else begin
         if (csr_wr_en) begin
            case (reg_index_type'(csr_index))
               REG_FRAME_WIDTH:  width_last_ff  <= width_last_in;
               REG_FRAME_HEIGHT: height_last_ff <= height_last_in;
               REG_FRAME_COUNT:  frame_last_ff  <= frame_last_in;
               default: ;
            endcase
         end
         if (advance) begin
            col_ff   <= col_in;
            row_ff   <= row_in;
            frame_ff <= frame_in;
         end
      end
   end

   assign pos.col        = col_ff;
   assign pos.row        = row_ff;
   assign pos.row_zero   = row_ff == '0;
   assign pos.frame_zero = frame_ff == '0;
   assign pos.end_col    = end_col;
   assign pos.last       = end_col & end_row & end_frame;

endmodule

[rtl/integral_volume_3d.sv]
// top level of the streaming 3-d summed-volume table
//
// takes one pixel beat per clock when not stalled, in frame, row, column order,
// and returns one result beat per pixel: the sum over all pixels of earlier
// rows and earlier columns of the same frame, plus the result at the same
// position of the previous frame. row 0 and column 0 of a frame give only the
// previous frame's value, and the first frame of a volume starts from zero.
// rsp_last_of_volume marks the final pixel of the final frame. sustained rate is
// one beat per clock while the output is not stalled; a pixel passes the input,
// store read and result registers. the reads of the two stores are registered:
// a 512 x 34 line store that carries the column sums down the frame and a
// 262144 x 38 volume store that carries each position's result into the next
// frame. neither store is cleared after reset: the first row and the first
// frame of a volume never use what is read from them, so no clearing pass is
// needed and the block takes pixels straight out of reset. size registers
// saturate into their legal range on write and are meant to be changed only
// while the block is empty; the position counters keep running across writes.
module integral_volume_3d (
   input  logic                            clock,
   input  logic                            reset,

   // size registers
   input  logic                            csr_wr_en,
   input  logic [iv3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [iv3_pkg::CSR_DATA_W-1:0]  csr_wdata,

   // pixel beats in
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [iv3_pkg::SAMPLE_W-1:0]    req_sample,

   // result beats out
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [iv3_pkg::SUM_W-1:0]       rsp_volume_sum,
   output logic                            rsp_last_of_volume
);
   import iv3_pkg::*;

   // the two stores, read in stage 0 and written back from stage 1
   logic [LINE_W-1:0] line_mem [MAX_WIDTH];
   logic [SUM_W-1:0]  vol_mem  [MAX_WIDTH * MAX_HEIGHT];

   pos_type pos;

   // stage 0: input register
   logic                s0_valid_ff;
   logic [SAMPLE_W-1:0] s0_sample_ff;
   pos_type             s0_pos_ff;

   // stage 1: store read data alongside the pixel
   logic                s1_valid_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   pos_type             s1_pos_ff;
   logic [LINE_W-1:0]   line_rd_ff;
   logic [SUM_W-1:0]    vol_rd_ff;

   // running sum of the current row, kept in stage 1 order
   logic [ROW_SUM_W-1:0] row_sum_ff, row_sum_in;

   // result register
   logic             rsp_valid_ff;
   logic [SUM_W-1:0] rsp_sum_ff;
   logic             rsp_last_ff;

   logic              out_free, s1_free, s0_free;
   logic              s0_adv, s1_adv, req_take;
   logic [LINE_W-1:0] spatial, line_wr;
   logic [SUM_W-1:0]  total;
   logic [VOL_ADDR_W-1:0] s0_vol_addr, s1_vol_addr;

   // a stage may load when it is empty or its contents move on in the same edge
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign s1_free   = ~s1_valid_ff | out_free;
   assign s0_free   = ~s0_valid_ff | s1_free;
   assign s1_adv    = s1_valid_ff & out_free;
   assign s0_adv    = s0_valid_ff & s1_free;
   assign req_stall = ~s0_free;
   assign req_take  = req_valid & s0_free;

   iv3_pos u_pos (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .advance   (req_take),
      .pos       (pos)
   );

   assign s0_vol_addr = {s0_pos_ff.row, s0_pos_ff.col};
   assign s1_vol_addr = {s1_pos_ff.row, s1_pos_ff.col};

   // spatial value of this position and the one a row below
   assign spatial    = s1_pos_ff.row_zero ? '0 : line_rd_ff;
   assign line_wr    = spatial + LINE_W'(row_sum_ff);
   assign total      = SUM_W'(spatial) + (s1_pos_ff.frame_zero ? '0 : vol_rd_ff);
   assign row_sum_in = s1_pos_ff.end_col ? '0 : row_sum_ff + ROW_SUM_W'(s1_sample_ff);

   // control and stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         row_sum_ff   <= '0;
      end else begin
         if (s0_free) begin
            s0_valid_ff <= req_valid;
         end
         if (s1_free) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (s1_adv) begin
            row_sum_ff <= row_sum_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_sample_ff <= req_sample;
         s0_pos_ff    <= pos;
      end
      if (s0_adv) begin
         s1_sample_ff <= s0_sample_ff;
         s1_pos_ff    <= s0_pos_ff;
      end
      if (s1_adv) begin
         rsp_sum_ff  <= total;
         rsp_last_ff <= s1_pos_ff.last;
      end
   end

   // line store: same column comes back at least two beats later
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         line_mem[s1_pos_ff.col] <= line_wr;
      end
      if (s0_adv) begin
         line_rd_ff <= line_mem[s0_pos_ff.col];
      end
   end

   // volume store: same position comes back a whole frame later
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         vol_mem[s1_vol_addr] <= total;
      end
      if (s0_adv) begin
         vol_rd_ff <= vol_mem[s0_vol_addr];
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_volume_sum     = rsp_sum_ff;
   assign rsp_last_of_volume = rsp_last_ff;

endmodule

[rtl/iv3_checker.sv]
// port-level checker of the integral volume block and its bind
`include "assert_macros.svh"

module iv3_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [iv3_pkg::SUM_W-1:0]    rsp_volume_sum,
   input logic                         rsp_last_of_volume
);
   import iv3_pkg::*;

   logic [INFLIGHT_W-1:0] inflight_ff, inflight_in;
   logic                  in_beat, out_beat;

   assign in_beat  = req_valid & ~req_stall;
   assign out_beat = rsp_valid & ~rsp_stall;
   assign inflight_in = inflight_ff + INFLIGHT_W'(in_beat) - INFLIGHT_W'(out_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // a stalled result beat holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid & rsp_stall, rsp_valid & $stable(rsp_volume_sum) & $stable(rsp_last_of_volume))
   // nothing comes out straight after reset
   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, ~rsp_valid)
   // the pipeline never holds more than three pixels
   `ASSERT_NOW(a_inflight_max, clock, reset, 1'b1, inflight_ff <= INFLIGHT_W'(MAX_INFLIGHT))
   // no result without a pixel behind it
   `ASSERT_NOW(a_no_invented, clock, reset, rsp_valid, inflight_ff != '0)
   // an empty block always takes a pixel
   `ASSERT_NOW(a_empty_ready, clock, reset, inflight_ff == '0, ~req_stall)

endmodule

bind integral_volume_3d iv3_checker u_iv3_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_volume_sum     (rsp_volume_sum),
   .rsp_last_of_volume (rsp_last_of_volume)
);

[tb/integral_volume_3d_checker.sv]
`timescale 1ns / 1ps
// watches both beat channels, predicts the summed-volume results and compares them
module integral_volume_3d_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_wr_en,
   input  logic [iv3_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [iv3_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [iv3_pkg::SAMPLE_W-1:0]    req_sample,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [iv3_pkg::SUM_W-1:0]       rsp_volume_sum,
   input  logic                            rsp_last_of_volume,
   output int                              error_count,
   output int                              pending_beats,
   output int                              results_checked,
   output int                              volumes_closed
);
   import iv3_pkg::*;

   typedef struct {
      logic [SUM_W-1:0] volume_sum;
      logic             last_of_volume;
   } volume_beat_type;

   volume_beat_type expected_sums [$];

   logic [WIDTH_CFG_W-1:0]  width_cfg;
   logic [HEIGHT_CFG_W-1:0] height_cfg;
   logic [COUNT_CFG_W-1:0]  count_cfg;

   // own copy of the running sums and the position
   bit   [ROW_SUM_W-1:0] row_sum;
   bit   [LINE_W-1:0]    column_sums [MAX_WIDTH];
   bit   [SUM_W-1:0]     last_frame_sums [MAX_HEIGHT*MAX_WIDTH];
   logic [COL_W-1:0]     col_pos;
   logic [ROW_W-1:0]     row_pos;
   logic [FRAME_W-1:0]   frame_pos;

   function automatic int unsigned clamp_size(int unsigned value, int unsigned lo,
                                              int unsigned hi);
      if (value < lo) return lo;
      if (value > hi) return hi;
      return value;
   endfunction

   task automatic accumulate_pixel(input logic [SAMPLE_W-1:0] pixel);
      int unsigned      ew, eh, ef, vaddr;
      logic [SUM_W-1:0] spatial, total;
      logic             end_col, end_row, end_frame;
      volume_beat_type  beat;
      ew = clamp_size(width_cfg, 2, MAX_WIDTH);
      eh = clamp_size(height_cfg, 2, MAX_HEIGHT);
      ef = clamp_size(count_cfg, 1, MAX_FRAMES);
      vaddr = row_pos * MAX_WIDTH + col_pos;
      end_col = (col_pos >= ew - 1);
      end_row = (row_pos >= eh - 1);
      end_frame = (frame_pos >= ef - 1);

      // column sum carried down from the row above, then extended for the row below
      spatial = (row_pos == 0) ? '0 : SUM_W'(column_sums[col_pos]);
      column_sums[col_pos] = LINE_W'(spatial + row_sum);
      row_sum = ROW_SUM_W'(row_sum + pixel);

      total = spatial;
      if (frame_pos != 0) total = SUM_W'(total + last_frame_sums[vaddr]);
      last_frame_sums[vaddr] = total;

      beat.volume_sum = total;
      beat.last_of_volume = end_col && end_row && end_frame;
      expected_sums.push_back(beat);

      if (end_col) begin
         col_pos = '0;
         row_sum = '0;
         if (end_row) begin
            row_pos = '0;
            frame_pos = end_frame ? '0 : frame_pos + 1'b1;
         end else begin
            row_pos = row_pos + 1'b1;
         end
      end else begin
         col_pos = col_pos + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      volume_beat_type want;
      if (reset) begin
         width_cfg = WIDTH_CFG_W'(MAX_WIDTH);
         height_cfg = HEIGHT_CFG_W'(MAX_HEIGHT);
         count_cfg = COUNT_CFG_W'(MAX_FRAMES);
         row_sum = '0;
         col_pos = '0;
         row_pos = '0;
         frame_pos = '0;
         expected_sums.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_FRAME_WIDTH:  width_cfg = csr_wdata[WIDTH_CFG_W-1:0];
               REG_FRAME_HEIGHT: height_cfg = csr_wdata[HEIGHT_CFG_W-1:0];
               REG_FRAME_COUNT:  count_cfg = csr_wdata[COUNT_CFG_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) accumulate_pixel(req_sample);
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (rsp_last_of_volume) volumes_closed++;
            if (expected_sums.size() == 0) begin
               $error("result beat with nothing expected: volume_sum %0d", rsp_volume_sum);
               error_count++;
            end else begin
               want = expected_sums.pop_front();
               if (rsp_volume_sum !== want.volume_sum) begin
                  $error("volume_sum: expected %0d, actual %0d",
                         want.volume_sum, rsp_volume_sum);
                  error_count++;
               end
               if (rsp_last_of_volume !== want.last_of_volume) begin
                  $error("last_of_volume: expected %0b, actual %0b",
                         want.last_of_volume, rsp_last_of_volume);
                  error_count++;
               end
            end
         end
      end
      pending_beats = expected_sums.size();
   end

endmodule

[tb/tb_integral_volume_3d.sv]
`timescale 1ns / 1ps
// top of the integral volume testbench: clock, reset, stimulus and verdict
module tb_integral_volume_3d;
   import iv3_pkg::*;

   // cycles with no beat on either channel before the run is called hung
   localparam int IDLE_LIMIT  = 2000;
   // pixels to spend on randomly sized small volumes
   localparam int SMALL_ITEMS = 740;

   typedef enum int {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_SOLID
   } stall_pattern_type;

   // every block input starts at a known value
   logic                   clock;
   logic                   reset = 1'b1;
   logic                   csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [SAMPLE_W-1:0]    req_sample = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [SUM_W-1:0]       rsp_volume_sum;
   logic                   rsp_last_of_volume;

   int error_count, pending_beats, results_checked, volumes_closed;
   int beats_sent, settings_run, idle_cycles;
   int burst_left = 1;
   int stall_left;
   stall_pattern_type stall_mode;

   integral_volume_3d uut (.*);

   integral_volume_3d_checker volume_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog: a run that stops moving beats is a failure
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver back-pressure: stretches of no stall, light and heavy random stall,
   // and solid stall runs, each lasting a random number of cycles
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (stall_left == 0) begin
            stall_mode = stall_pattern_type'($urandom_range(0, 3));
            stall_left = (stall_mode == STALL_SOLID) ? $urandom_range(1, 25)
                                                     : $urandom_range(20, 200);
         end
         stall_left--;
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 9) < 3);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 9) < 8);
            default:     rsp_stall <= 1'b1;
         endcase
      end
   end

   function automatic int clamp_size(int value, int lo, int hi);
      if (value < lo) return lo;
      if (value > hi) return hi;
      return value;
   endfunction

   // pixel values lean towards the extremes so the sums get large
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      logic [SAMPLE_W-1:0] pixel;
      pixel = SAMPLE_W'($urandom);
      case ($urandom_range(0, 9))
         0: pixel = '0;
         1, 2: pixel = '1;
         3: pixel = SAMPLE_W'($urandom_range(0, 15));
         default: ;
      endcase
      return pixel;
   endfunction

   // one register write; called and returns at a falling edge, with the
   // write enable low again before the next write can start
   task automatic write_size_reg(input reg_index_type idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_sizes(input int w_raw, input int h_raw, input int f_raw);
      write_size_reg(REG_FRAME_WIDTH, CSR_DATA_W'(w_raw));
      write_size_reg(REG_FRAME_HEIGHT, CSR_DATA_W'(h_raw));
      write_size_reg(REG_FRAME_COUNT, CSR_DATA_W'(f_raw));
      settings_run++;
   endtask

   // one pixel beat; valid stays up across a burst, and a burst ends in a
   // random gap with valid low (sometimes none, so bursts run back to back)
   task automatic send_pixel(input logic [SAMPLE_W-1:0] pixel);
      int gap;
      req_valid <= 1'b1;
      req_sample <= pixel;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      beats_sent++;
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // stop sending, wait for every result, then let the three-stage pipe
   // sit idle before any register is touched
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (pending_beats != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   initial begin
      logic [SAMPLE_W-1:0] corner_pixels [12];
      int w_raw, h_raw, f_raw, volumes, items, small_items;
      corner_pixels = '{16'h0001, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'h5555,
                        16'hAAAA, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h0000};
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset sizes (512 x 512 x 16): two pixels of row 0, all zero results
      send_pixel(16'hFFFF);
      send_pixel(16'h0000);
      finish_phase();

      // shrink to 2 x 3 x 2 mid-row: the column counter is already past the
      // new width, so the next pixel closes row 0; the rest of the volume
      // also reads line and volume entries written under the old width
      set_sizes(2, 3, 2);
      for (int i = 0; i < 11; i++) send_pixel(corner_pixels[i]);
      finish_phase();

      // width written below range saturates to 2; after two of four frames
      // the count drops to one, so the frame counter is past its limit and
      // the third frame ends the volume
      set_sizes(0, 2, 4);
      for (int i = 0; i < 8; i++) send_pixel(corner_pixels[i]);
      finish_phase();
      write_size_reg(REG_FRAME_COUNT, CSR_DATA_W'(1));
      for (int i = 8; i < 12; i++) send_pixel(corner_pixels[i]);
      finish_phase();

      // widest row: width written above range saturates to 512, count 0 to 1;
      // row 0 runs full width, then row 1 at width 2 closes the volume
      set_sizes(1023, 2, 0);
      repeat (MAX_WIDTH) send_pixel(pick_sample());
      finish_phase();
      write_size_reg(REG_FRAME_WIDTH, CSR_DATA_W'(2));
      repeat (2) send_pixel(pick_sample());
      finish_phase();

      // deepest volume, count saturating to 16
      set_sizes(2, 2, 31);
      repeat (4 * MAX_FRAMES) send_pixel(pick_sample());
      finish_phase();

      // random small sizes, whole volumes each, now and then out of range
      small_items = 0;
      while (small_items < SMALL_ITEMS) begin
         w_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 9);
         h_raw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
         f_raw = $urandom_range(0, 5);
         if ($urandom_range(0, 9) == 0) begin
            f_raw = $urandom_range(16, 31);
            w_raw = 2;
            h_raw = $urandom_range(2, 3);
         end
         items = clamp_size(w_raw, 2, MAX_WIDTH) * clamp_size(h_raw, 2, MAX_HEIGHT)
                 * clamp_size(f_raw, 1, MAX_FRAMES);
         volumes = (items > 60) ? 1 : $urandom_range(1, 3);
         set_sizes(w_raw, h_raw, f_raw);
         repeat (items * volumes) send_pixel(pick_sample());
         finish_phase();
         small_items += items * volumes;
      end

      $display("sent %0d pixel beats over %0d size settings, including saturated sizes",
               beats_sent, settings_run);
      $display("and mid-volume size changes; %0d result beats checked, %0d volumes closed",
               results_checked, volumes_closed);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/iv3_pkg.sv
rtl/iv3_pos.sv
rtl/integral_volume_3d.sv
rtl/iv3_checker.sv
tb/integral_volume_3d_checker.sv
tb/tb_integral_volume_3d.sv
